>>> sv/rsrm_pkg.sv
// ----------------------------------------------------------------------------
// rsrm_pkg
// Shared types and constants for the record-size run map.
// ----------------------------------------------------------------------------
package rsrm_pkg;

    localparam int MAX_RUNS  = 16;
    localparam int RUN_AW    = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CNT_W     = $clog2(MAX_RUNS + 1);
    localparam int REC_W     = 31;
    localparam int SIZE_W    = 24;
    localparam int RUNS_W    = 5;

    localparam logic [SIZE_W-1:0] RESET_DEFAULT_SIZE = SIZE_W'(32 * 1024);

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef struct packed {
        logic [REC_W-1:0]  first;
        logic [REC_W-1:0]  last;
        logic [SIZE_W-1:0] bytes;
    } t_run;

    localparam int RUN_W = $bits(t_run);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_APPEND = 3'b100
    } t_state;

endpackage

>>> sv/rsrm_ram.sv
// ----------------------------------------------------------------------------
// rsrm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rsrm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/record_size_run_map.sv
// A lookup on an empty list answers straight from S_IDLE; otherwise the run
// table is scanned in S_SCAN (one run table read per cycle), and an update
// that appends a run passes through S_APPEND (an update on an empty list goes
// straight from S_IDLE to S_APPEND). One request at a time.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset: synchronous active-low; run list empties, default size = 32768.
// ----------------------------------------------------------------------------
// record_size_run_map
// Sorted run list of record sizes kept in a RAM; lookup and update sequencer.
// ----------------------------------------------------------------------------
module record_size_run_map import rsrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [REC_W-1:0]  i_record_index,
    input  logic [SIZE_W-1:0] i_record_bytes,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_default_size,
    output logic              o_strobe,
    output logic [SIZE_W-1:0] o_size_out,
    output logic              o_from_table,
    output logic              o_overflow,
    output logic [RUNS_W-1:0] o_runs_used
);

    t_state             r_state,   n_state;
    logic [RUN_AW-1:0]  r_idx,     n_idx;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [SIZE_W-1:0]  r_default;
    logic               r_req_type, n_req_type;
    logic [REC_W-1:0]   r_rec,     n_rec;
    logic [SIZE_W-1:0]  r_bytes,   n_bytes;
    logic               r_strobe,  n_strobe;
    logic [SIZE_W-1:0]  r_size,    n_size;
    logic               r_from,    n_from;
    logic               r_ovf,     n_ovf;

    logic               ram_we;
    logic [RUN_AW-1:0]  ram_waddr;
    t_run               ram_wdata;
    logic               ram_re;
    logic [RUN_AW-1:0]  ram_raddr;
    logic [RUN_W-1:0]   ram_rdata;
    t_run               cur;

    logic [CNT_W-1:0]   idx_next;
    logic               at_end;
    logic               upd_hit;
    logic [CNT_W-1:0]   eff_count;

    rsrm_ram #(
        .DEPTH (MAX_RUNS),
        .WIDTH (RUN_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cur      = t_run'(ram_rdata);
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign at_end   = (idx_next >= r_count);
    // update covers record one past the run's end as well
    assign upd_hit  = ({1'b0, r_rec} <= ({1'b0, cur.last} + (REC_W+1)'(1)));
    assign eff_count = (i_req_type == REQ_UPDATE && i_record_index == '0) ? '0 : r_count;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_req_type = r_req_type;
        n_rec      = r_rec;
        n_bytes    = r_bytes;
        n_strobe   = 1'b0;
        n_size     = r_size;
        n_from     = r_from;
        n_ovf      = r_ovf;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = '{first: r_rec, last: r_rec, bytes: r_bytes};
        ram_re     = 1'b0;
        ram_raddr  = idx_next[RUN_AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req_type = i_req_type;
                    n_rec      = i_record_index;
                    n_bytes    = i_record_bytes;
                    n_count    = eff_count;
                    n_idx      = '0;
                    if (eff_count == '0) begin
                        if (i_req_type == REQ_LOOKUP) begin
                            n_strobe = 1'b1;
                            n_size   = r_default;
                            n_from   = 1'b0;
                            n_ovf    = 1'b0;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_req_type == REQ_LOOKUP) begin
                    if (r_rec <= cur.last) begin
                        n_strobe = 1'b1;
                        n_size   = cur.bytes;
                        n_from   = 1'b1;
                        n_ovf    = 1'b0;
                        n_state  = S_IDLE;
                    end else if (at_end) begin
                        n_strobe = 1'b1;
                        n_size   = r_default;
                        n_from   = 1'b0;
                        n_ovf    = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        ram_re = 1'b1;
                        n_idx  = idx_next[RUN_AW-1:0];
                    end
                end else begin
                    if (upd_hit) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx;
                        n_count   = idx_next;
                        if (r_rec == cur.first || r_bytes == cur.bytes) begin
                            // rewrite the covering run in place
                            ram_wdata = '{first: cur.first, last: r_rec, bytes: r_bytes};
                            n_strobe  = 1'b1;
                            n_size    = r_bytes;
                            n_from    = 1'b0;
                            n_ovf     = 1'b0;
                            n_state   = S_IDLE;
                        end else begin
                            // trim: run ends just before the record
                            ram_wdata = '{first: cur.first, last: r_rec - REC_W'(1),
                                          bytes: cur.bytes};
                            n_state   = S_APPEND;
                        end
                    end else if (at_end) begin
                        n_state = S_APPEND;
                    end else begin
                        ram_re = 1'b1;
                        n_idx  = idx_next[RUN_AW-1:0];
                    end
                end
            end
            S_APPEND: begin
                n_strobe = 1'b1;
                n_size   = r_bytes;
                n_from   = 1'b0;
                n_state  = S_IDLE;
                if (r_count >= CNT_W'(MAX_RUNS)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_ovf     = 1'b0;
                    ram_we    = 1'b1;
                    ram_waddr = r_count[RUN_AW-1:0];
                    ram_wdata = '{first: r_rec, last: r_rec, bytes: r_bytes};
                    n_count   = r_count + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_strobe  <= 1'b0;
            r_default <= RESET_DEFAULT_SIZE;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_valid) begin
                r_default <= i_cfg_default_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_req_type <= n_req_type;
        r_rec      <= n_rec;
        r_bytes    <= n_bytes;
        r_size     <= n_size;
        r_from     <= n_from;
        r_ovf      <= n_ovf;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = r_strobe;
    assign o_size_out   = r_size;
    assign o_from_table = r_from;
    assign o_overflow   = r_ovf;
    assign o_runs_used  = RUNS_W'(r_count);

endmodule
